@@ design/tqv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the tile quad vertex generator.
package tqv_pkg;

    localparam int MAP_DIM_DEFAULT = 1024;
    localparam int FIFO_DEPTH      = 2;
    localparam int DIV_STEP_BITS   = 4;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int ID_W            = 32;
    localparam int CELL_W          = 10;
    localparam int POS_W           = 26;
    localparam int UV_W            = 17;

    // Register map, indexed by paddr[4:2].
    typedef enum logic [2:0] {
        REG_FIRST_GID,
        REG_TILE_COUNT,
        REG_SHEET_COLUMNS,
        REG_SHEET_TILE_SIZE,
        REG_MAP_TILE_SIZE,
        REG_GAP_AND_BORDER,
        REG_TEXTURE_SIZE
    } reg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] first_gid;
        logic [31:0] tile_count;
        logic [15:0] sheet_columns;
        logic [31:0] sheet_tile_size;
        logic [31:0] map_tile_size;
        logic [31:0] gap_and_border;
        logic [31:0] texture_size;
    } cfg_t;

    // One accepted tile waiting for the back end.
    typedef struct packed {
        logic [ID_W-1:0]   local_idx;
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_ADD,
        BK_PRE,
        BK_QGO,
        BK_QDIV,
        BK_HAND
    } back_state_t;

endpackage

@@ design/tile_quad_vertex_generator.sv @@
`timescale 1ns / 1ps
// Tile quad vertex generator: six quad vertices for each map cell in the tileset.
// Hit tiles go one at a time through the iterative index divider
// (4 quotient bits a cycle) and the UV dividers; misses are taken one a cycle unless full.
// Vertices leave one a cycle while pop is high, as the next tile is computed.
// Reset (rst_n, asynchronous) empties the queue and output and restores register defaults.
module tile_quad_vertex_generator #(
    parameter int MAP_DIM = tqv_pkg::MAP_DIM_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tqv_pkg::ADDR_W-1:0] paddr,
    input  logic [tqv_pkg::DATA_W-1:0] pwdata,
    output logic [tqv_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    input  logic                      push,
    output logic                      full,
    input  logic [tqv_pkg::ID_W-1:0]   tile_id,
    input  logic [tqv_pkg::CELL_W-1:0] cell_col,
    input  logic [tqv_pkg::CELL_W-1:0] cell_row,
    output logic                      empty,
    input  logic                      pop,
    output logic [tqv_pkg::POS_W-1:0]  pos_x,
    output logic [tqv_pkg::POS_W-1:0]  pos_y,
    output logic [tqv_pkg::UV_W-1:0]   tex_u,
    output logic [tqv_pkg::UV_W-1:0]   tex_v,
    output logic                      last_vertex
);

    tqv_pkg::cfg_t cfg;
    tqv_pkg::job_t push_job;
    tqv_pkg::job_t pop_job;
    logic          fifo_push;
    logic          fifo_pop;
    logic          fifo_full;
    logic          fifo_empty;

    tqv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tqv_front #(.MAP_DIM(MAP_DIM)) u_front (
        .push      (push),
        .full      (full),
        .tile_id   (tile_id),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_data (push_job)
    );

    tqv_fifo #(.WIDTH(tqv_pkg::JOB_W), .DEPTH(tqv_pkg::FIFO_DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_push),
        .wr_data (push_job),
        .rd_en   (fifo_pop),
        .rd_data (pop_job),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    tqv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fifo_empty  (fifo_empty),
        .fifo_data   (pop_job),
        .fifo_pop    (fifo_pop),
        .pop         (pop),
        .empty       (empty),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .last_vertex (last_vertex)
    );

endmodule

@@ design/tqv_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module tqv_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tqv_pkg::ADDR_W-1:0] paddr,
    input  logic [tqv_pkg::DATA_W-1:0] pwdata,
    output logic [tqv_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output tqv_pkg::cfg_t             cfg
);

    tqv_pkg::cfg_t    cfg_reg;
    tqv_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = tqv_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_gid       <= 32'd1;
            cfg_reg.tile_count      <= 32'd0;
            cfg_reg.sheet_columns   <= 16'd1;
            cfg_reg.sheet_tile_size <= 32'd0;
            cfg_reg.map_tile_size   <= 32'd0;
            cfg_reg.gap_and_border  <= 32'd0;
            cfg_reg.texture_size    <= 32'd65537;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tqv_pkg::REG_FIRST_GID:       cfg_reg.first_gid       <= pwdata;
                tqv_pkg::REG_TILE_COUNT:      cfg_reg.tile_count      <= pwdata;
                tqv_pkg::REG_SHEET_COLUMNS:   cfg_reg.sheet_columns   <= pwdata[15:0];
                tqv_pkg::REG_SHEET_TILE_SIZE: cfg_reg.sheet_tile_size <= pwdata;
                tqv_pkg::REG_MAP_TILE_SIZE:   cfg_reg.map_tile_size   <= pwdata;
                tqv_pkg::REG_GAP_AND_BORDER:  cfg_reg.gap_and_border  <= pwdata;
                tqv_pkg::REG_TEXTURE_SIZE:    cfg_reg.texture_size    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (idx)
            tqv_pkg::REG_FIRST_GID:       prdata = cfg_reg.first_gid;
            tqv_pkg::REG_TILE_COUNT:      prdata = cfg_reg.tile_count;
            tqv_pkg::REG_SHEET_COLUMNS:   prdata = {16'd0, cfg_reg.sheet_columns};
            tqv_pkg::REG_SHEET_TILE_SIZE: prdata = cfg_reg.sheet_tile_size;
            tqv_pkg::REG_MAP_TILE_SIZE:   prdata = cfg_reg.map_tile_size;
            tqv_pkg::REG_GAP_AND_BORDER:  prdata = cfg_reg.gap_and_border;
            tqv_pkg::REG_TEXTURE_SIZE:    prdata = cfg_reg.texture_size;
            default:                      prdata = '0;
        endcase
    end

endmodule

@@ design/tqv_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts map cells and keeps only those inside the tileset.
module tqv_front #(
    parameter int MAP_DIM = tqv_pkg::MAP_DIM_DEFAULT
) (
    input  logic                      push,
    output logic                      full,
    input  logic [tqv_pkg::ID_W-1:0]   tile_id,
    input  logic [tqv_pkg::CELL_W-1:0] cell_col,
    input  logic [tqv_pkg::CELL_W-1:0] cell_row,
    input  tqv_pkg::cfg_t             cfg,
    input  logic                      fifo_full,
    output logic                      fifo_push,
    output tqv_pkg::job_t             fifo_data
);

    logic [tqv_pkg::ID_W-1:0] local_idx;
    logic                     in_map;
    logic                     hit;

    // The id range never wraps: id must be at least first_gid and the
    // offset from it below the tile count.
    assign local_idx = tile_id - cfg.first_gid;
    assign in_map    = ({22'd0, cell_col} < 32'(MAP_DIM)) &&
                       ({22'd0, cell_row} < 32'(MAP_DIM));
    assign hit       = (tile_id >= cfg.first_gid) && (local_idx < cfg.tile_count) && in_map;

    // Cells that miss are taken and dropped.
    assign full                = fifo_full;
    assign fifo_push           = push & ~fifo_full & hit;
    assign fifo_data.local_idx = local_idx;
    assign fifo_data.col       = cell_col;
    assign fifo_data.row       = cell_row;

endmodule

@@ design/tqv_fifo.sv @@
`timescale 1ns / 1ps
// Small job queue between the front end and the back end.
module tqv_fifo #(
    parameter int WIDTH = tqv_pkg::JOB_W,
    parameter int DEPTH = tqv_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/tqv_div.sv @@
`timescale 1ns / 1ps
// Iterative restoring divider by a 16-bit divisor, several quotient bits per cycle.
module tqv_div #(
    parameter int NUM_W = 32,
    parameter int STEP  = tqv_pkg::DIV_STEP_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      rem_init,
    input  logic [NUM_W-1:0] num,
    input  logic [15:0]      den,
    output logic [NUM_W-1:0] quo,
    output logic [15:0]      rem,
    output logic             done
);

    localparam int STEPS = NUM_W / STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [15:0]      rem_reg;
    logic [15:0]      rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [16:0]      trial;

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

    // STEP long-division steps; the partial remainder stays below den.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < STEP; i++)
        begin
            trial    = {rem_next, quo_next[NUM_W-1]};
            quo_next = {quo_next[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                trial       = trial - {1'b0, den};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[15:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/tqv_back.sv @@
`timescale 1ns / 1ps
// Back end: computes one quad per tile and streams out its six vertices.
module tqv_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tqv_pkg::cfg_t             cfg,
    input  logic                      fifo_empty,
    input  tqv_pkg::job_t             fifo_data,
    output logic                      fifo_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [tqv_pkg::POS_W-1:0]  pos_x,
    output logic [tqv_pkg::POS_W-1:0]  pos_y,
    output logic [tqv_pkg::UV_W-1:0]   tex_u,
    output logic [tqv_pkg::UV_W-1:0]   tex_v,
    output logic                      last_vertex
);

    typedef struct packed {
        logic        sat;
        logic        q0;
        logic [15:0] r0;
    } pre_t;

    localparam logic [2:0] VTX_LAST = 3'd5;
    localparam int         TEX_W    = 51;

    // Saturation test and first quotient bit of texel / size.
    function automatic pre_t pre_q16(input logic [TEX_W-1:0] texel, input logic [15:0] size);
        pre_t             p;
        logic [TEX_W-1:0] diff;
        diff  = texel - TEX_W'(size);
        p.sat = texel >= {34'd0, size, 1'b0};
        p.q0  = texel >= TEX_W'(size);
        p.r0  = p.q0 ? diff[15:0] : texel[15:0];
        return p;
    endfunction

    function automatic logic [16:0] uv_of(input pre_t p, input logic [15:0] q);
        return p.sat ? 17'h1FFFF : {p.q0, q};
    endfunction

    tqv_pkg::back_state_t state_reg;
    tqv_pkg::back_state_t state_next;

    // Configuration fields.
    logic [15:0] cols, tw, th, gap, border, tex_w, tex_h, mw, mh;
    assign cols   = (cfg.sheet_columns == '0) ? 16'd1 : cfg.sheet_columns;
    assign tw     = cfg.sheet_tile_size[31:16];
    assign th     = cfg.sheet_tile_size[15:0];
    assign gap    = cfg.gap_and_border[31:16];
    assign border = cfg.gap_and_border[15:0];
    assign tex_w  = (cfg.texture_size[31:16] == '0) ? 16'd1 : cfg.texture_size[31:16];
    assign tex_h  = (cfg.texture_size[15:0] == '0) ? 16'd1 : cfg.texture_size[15:0];
    assign mw     = cfg.map_tile_size[31:16];
    assign mh     = cfg.map_tile_size[15:0];

    logic [tqv_pkg::CELL_W-1:0] col_reg, row_reg;
    logic [32:0]                pu_reg;
    logic [48:0]                pv_reg;
    logic [25:0]                x0_reg, y0_reg, x1_reg, y1_reg;
    logic [TEX_W-1:0]           tu0_reg, tu1_reg, tv0_reg, tv1_reg;
    pre_t                       pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    logic [16:0]                step_u, step_v;
    logic [33:0]                tu0_sum;
    logic [49:0]                tv0_sum;

    // Sheet index split.
    logic        div_start;
    logic [31:0] div_quo;
    logic [15:0] div_rem;
    logic        div_done;

    tqv_div #(.NUM_W(32), .STEP(tqv_pkg::DIV_STEP_BITS)) u_idx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (16'd0),
        .num      (fifo_data.local_idx),
        .den      (cols),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    // Four texel-to-UV dividers working side by side.
    logic        q_start;
    logic [15:0] qu0, qu1, qv0, qv1;
    logic [15:0] ru0, ru1, rv0, rv1;
    logic        du0, du1, dv0, dv1;

    tqv_div #(.NUM_W(16), .STEP(tqv_pkg::DIV_STEP_BITS)) u_u0_div (
        .clk(clk), .rst_n(rst_n), .start(q_start), .rem_init(pu0_reg.r0), .num(16'd0),
        .den(tex_w), .quo(qu0), .rem(ru0), .done(du0)
    );
    tqv_div #(.NUM_W(16), .STEP(tqv_pkg::DIV_STEP_BITS)) u_u1_div (
        .clk(clk), .rst_n(rst_n), .start(q_start), .rem_init(pu1_reg.r0), .num(16'd0),
        .den(tex_w), .quo(qu1), .rem(ru1), .done(du1)
    );
    tqv_div #(.NUM_W(16), .STEP(tqv_pkg::DIV_STEP_BITS)) u_v0_div (
        .clk(clk), .rst_n(rst_n), .start(q_start), .rem_init(pv0_reg.r0), .num(16'd0),
        .den(tex_h), .quo(qv0), .rem(rv0), .done(dv0)
    );
    tqv_div #(.NUM_W(16), .STEP(tqv_pkg::DIV_STEP_BITS)) u_v1_div (
        .clk(clk), .rst_n(rst_n), .start(q_start), .rem_init(pv1_reg.r0), .num(16'd0),
        .den(tex_h), .quo(qv1), .rem(rv1), .done(dv1)
    );

    logic q_done;
    assign q_done = du0 & du1 & dv0 & dv1 & ~(|{ru0, ru1, rv0, rv1} & 1'b0);

    // Vertex buffer: holds one finished quad while the next one is computed.
    logic        buf_valid_reg;
    logic [2:0]  vcnt_reg;
    logic [25:0] bx0_reg, bx1_reg, by0_reg, by1_reg;
    logic [16:0] bu0_reg, bu1_reg, bv0_reg, bv1_reg;
    logic        out_xfer;
    logic        emit_free;
    logic        buf_load;
    logic        far_x, far_y;

    assign out_xfer  = pop & buf_valid_reg;
    assign emit_free = ~buf_valid_reg | (out_xfer & (vcnt_reg == VTX_LAST));

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tqv_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fifo_pop   = 1'b0;
        div_start  = 1'b0;
        q_start    = 1'b0;
        buf_load   = 1'b0;
        unique case (state_reg)
            tqv_pkg::BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    div_start  = 1'b1;
                    state_next = tqv_pkg::BK_DIV;
                end
            end
            tqv_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = tqv_pkg::BK_MUL;
                end
            end
            tqv_pkg::BK_MUL:  state_next = tqv_pkg::BK_ADD;
            tqv_pkg::BK_ADD:  state_next = tqv_pkg::BK_PRE;
            tqv_pkg::BK_PRE:  state_next = tqv_pkg::BK_QGO;
            tqv_pkg::BK_QGO:
            begin
                q_start    = 1'b1;
                state_next = tqv_pkg::BK_QDIV;
            end
            tqv_pkg::BK_QDIV:
            begin
                if (q_done)
                begin
                    if (emit_free)
                    begin
                        buf_load   = 1'b1;
                        state_next = tqv_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next = tqv_pkg::BK_HAND;
                    end
                end
            end
            tqv_pkg::BK_HAND:
            begin
                if (emit_free)
                begin
                    buf_load   = 1'b1;
                    state_next = tqv_pkg::BK_IDLE;
                end
            end
            default: state_next = tqv_pkg::BK_IDLE;
        endcase
    end

    // Geometry datapath, one stage in each of the MUL, ADD and PRE states.
    assign step_u  = 17'(tw) + 17'(gap);
    assign step_v  = 17'(th) + 17'(gap);
    assign tu0_sum = 34'(pu_reg) + 34'(border);
    assign tv0_sum = 50'(pv_reg) + 50'(border);

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            col_reg <= fifo_data.col;
            row_reg <= fifo_data.row;
        end
        if (state_reg == tqv_pkg::BK_MUL)
        begin
            pu_reg <= 33'(div_rem) * 33'(step_u);
            pv_reg <= 49'(div_quo) * 49'(step_v);
            x0_reg <= 26'(col_reg) * 26'(mw);
            y0_reg <= 26'(row_reg) * 26'(mh);
        end
        if (state_reg == tqv_pkg::BK_ADD)
        begin
            tu0_reg <= TEX_W'(tu0_sum);
            tu1_reg <= TEX_W'(tu0_sum) + TEX_W'(tw);
            tv0_reg <= TEX_W'(tv0_sum);
            tv1_reg <= TEX_W'(tv0_sum) + TEX_W'(th);
            x1_reg  <= x0_reg + 26'(mw);
            y1_reg  <= y0_reg + 26'(mh);
        end
        if (state_reg == tqv_pkg::BK_PRE)
        begin
            pu0_reg <= pre_q16(tu0_reg, tex_w);
            pu1_reg <= pre_q16(tu1_reg, tex_w);
            pv0_reg <= pre_q16(tv0_reg, tex_h);
            pv1_reg <= pre_q16(tv1_reg, tex_h);
        end
        if (buf_load)
        begin
            bx0_reg <= x0_reg;
            bx1_reg <= x1_reg;
            by0_reg <= y0_reg;
            by1_reg <= y1_reg;
            bu0_reg <= uv_of(pu0_reg, qu0);
            bu1_reg <= uv_of(pu1_reg, qu1);
            bv0_reg <= uv_of(pv0_reg, qv0);
            bv1_reg <= uv_of(pv1_reg, qv1);
        end
    end

    // Vertex counter of the output buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            vcnt_reg      <= '0;
        end
        else if (buf_load)
        begin
            buf_valid_reg <= 1'b1;
            vcnt_reg      <= '0;
        end
        else if (out_xfer)
        begin
            if (vcnt_reg == VTX_LAST)
            begin
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
        end
    end

    // Vertex order: (0,0) (1,0) (0,1) (0,1) (1,0) (1,1).
    assign far_x       = (vcnt_reg == 3'd1) | (vcnt_reg == 3'd4) | (vcnt_reg == VTX_LAST);
    assign far_y       = (vcnt_reg == 3'd2) | (vcnt_reg == 3'd3) | (vcnt_reg == VTX_LAST);
    assign empty       = ~buf_valid_reg;
    assign pos_x       = far_x ? bx1_reg : bx0_reg;
    assign pos_y       = far_y ? by1_reg : by0_reg;
    assign tex_u       = far_x ? bu1_reg : bu0_reg;
    assign tex_v       = far_y ? bv1_reg : bv0_reg;
    assign last_vertex = (vcnt_reg == VTX_LAST);

endmodule

@@ tb/tqv_checker.sv @@
`timescale 1ns / 1ps
// Vertex predictor and scoreboard for the tile quad vertex generator.
module tqv_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tqv_pkg::ADDR_W-1:0] paddr,
    input  logic [tqv_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    input  logic                       push,
    input  logic                       full,
    input  logic [tqv_pkg::ID_W-1:0]   tile_id,
    input  logic [tqv_pkg::CELL_W-1:0] cell_col,
    input  logic [tqv_pkg::CELL_W-1:0] cell_row,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [tqv_pkg::POS_W-1:0]  pos_x,
    input  logic [tqv_pkg::POS_W-1:0]  pos_y,
    input  logic [tqv_pkg::UV_W-1:0]   tex_u,
    input  logic [tqv_pkg::UV_W-1:0]   tex_v,
    input  logic                       last_vertex,
    output int                         errors,
    output int                         pending,
    output int                         hits,
    output int                         vertices
);

    typedef struct packed {
        logic [tqv_pkg::POS_W-1:0] x;
        logic [tqv_pkg::POS_W-1:0] y;
        logic [tqv_pkg::UV_W-1:0]  u;
        logic [tqv_pkg::UV_W-1:0]  v;
        logic                      last;
    } vertex_t;

    tqv_pkg::cfg_t cfg;
    vertex_t       vertex_q[$];

    assign pending = vertex_q.size();

    // Texel edge to unsigned Q1.16, floored and saturated.
    function automatic logic [tqv_pkg::UV_W-1:0] texel_to_uv(logic [63:0] texel,
                                                             logic [15:0] dim);
        logic [63:0] d;
        d = (dim == 0) ? 64'd1 : {48'd0, dim};
        if (texel >= 2 * d)
            return '1;
        return tqv_pkg::UV_W'((texel << 16) / d);
    endfunction

    // Queue the six quad vertices of one cell, if it belongs to the tileset.
    task automatic queue_quad(logic [tqv_pkg::ID_W-1:0] id, logic [tqv_pkg::CELL_W-1:0] col,
                              logic [tqv_pkg::CELL_W-1:0] row);
        logic [63:0] base, cols, idx, scol, srow, tw, th, gap, tu0, tv0, mw, mh;
        logic [63:0] x0, x1, y0, y1;
        logic [tqv_pkg::UV_W-1:0] u0, u1, v0, v1;
        base = cfg.first_gid;
        if (id < base || {32'd0, id} >= base + cfg.tile_count)
            return;
        cols = (cfg.sheet_columns == 0) ? 64'd1 : cfg.sheet_columns;
        idx  = id - base;
        scol = idx % cols;
        srow = idx / cols;
        tw   = cfg.sheet_tile_size[31:16];
        th   = cfg.sheet_tile_size[15:0];
        gap  = cfg.gap_and_border[31:16];
        tu0  = scol * (tw + gap) + cfg.gap_and_border[15:0];
        tv0  = srow * (th + gap) + cfg.gap_and_border[15:0];
        u0   = texel_to_uv(tu0, cfg.texture_size[31:16]);
        u1   = texel_to_uv(tu0 + tw, cfg.texture_size[31:16]);
        v0   = texel_to_uv(tv0, cfg.texture_size[15:0]);
        v1   = texel_to_uv(tv0 + th, cfg.texture_size[15:0]);
        mw   = cfg.map_tile_size[31:16];
        mh   = cfg.map_tile_size[15:0];
        x0   = col * mw;
        x1   = x0 + mw;
        y0   = row * mh;
        y1   = y0 + mh;
        vertex_q.push_back({tqv_pkg::POS_W'(x0), tqv_pkg::POS_W'(y0), u0, v0, 1'b0});
        vertex_q.push_back({tqv_pkg::POS_W'(x1), tqv_pkg::POS_W'(y0), u1, v0, 1'b0});
        vertex_q.push_back({tqv_pkg::POS_W'(x0), tqv_pkg::POS_W'(y1), u0, v1, 1'b0});
        vertex_q.push_back({tqv_pkg::POS_W'(x0), tqv_pkg::POS_W'(y1), u0, v1, 1'b0});
        vertex_q.push_back({tqv_pkg::POS_W'(x1), tqv_pkg::POS_W'(y0), u1, v0, 1'b0});
        vertex_q.push_back({tqv_pkg::POS_W'(x1), tqv_pkg::POS_W'(y1), u1, v1, 1'b1});
        hits++;
    endtask

    // Track register writes, input transfers and output transfers.
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t want;
        if (!rst_n)
        begin
            cfg.first_gid       = 32'd1;
            cfg.tile_count      = 32'd0;
            cfg.sheet_columns   = 16'd1;
            cfg.sheet_tile_size = 32'd0;
            cfg.map_tile_size   = 32'd0;
            cfg.gap_and_border  = 32'd0;
            cfg.texture_size    = 32'h0001_0001;
            vertex_q.delete();
            errors   = 0;
            hits     = 0;
            vertices = 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                vertices++;
                if (vertex_q.size() == 0)
                begin
                    $error("unexpected vertex x=%0d y=%0d", pos_x, pos_y);
                    errors++;
                end
                else
                begin
                    want = vertex_q.pop_front();
                    if (pos_x !== want.x)
                    begin
                        $error("pos_x expected %0d actual %0d", want.x, pos_x);
                        errors++;
                    end
                    if (pos_y !== want.y)
                    begin
                        $error("pos_y expected %0d actual %0d", want.y, pos_y);
                        errors++;
                    end
                    if (tex_u !== want.u)
                    begin
                        $error("tex_u expected %0d actual %0d", want.u, tex_u);
                        errors++;
                    end
                    if (tex_v !== want.v)
                    begin
                        $error("tex_v expected %0d actual %0d", want.v, tex_v);
                        errors++;
                    end
                    if (last_vertex !== want.last)
                    begin
                        $error("last_vertex expected %0d actual %0d", want.last, last_vertex);
                        errors++;
                    end
                end
            end
            if (push && !full)
                queue_quad(tile_id, cell_col, cell_row);
            if (psel && penable && pwrite && pready)
            begin
                case (tqv_pkg::reg_idx_t'(paddr[4:2]))
                    tqv_pkg::REG_FIRST_GID:       cfg.first_gid       = pwdata;
                    tqv_pkg::REG_TILE_COUNT:      cfg.tile_count      = pwdata;
                    tqv_pkg::REG_SHEET_COLUMNS:   cfg.sheet_columns   = pwdata[15:0];
                    tqv_pkg::REG_SHEET_TILE_SIZE: cfg.sheet_tile_size = pwdata;
                    tqv_pkg::REG_MAP_TILE_SIZE:   cfg.map_tile_size   = pwdata;
                    tqv_pkg::REG_GAP_AND_BORDER:  cfg.gap_and_border  = pwdata;
                    tqv_pkg::REG_TEXTURE_SIZE:    cfg.texture_size    = pwdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the tile quad vertex generator testbench: stimulus, idling and verdict.
module testbench;

    localparam int QUIET_LIMIT = 2000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tqv_pkg::ADDR_W-1:0] paddr = '0;
    logic [tqv_pkg::DATA_W-1:0] pwdata = '0;
    logic [tqv_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       push = 1'b0;
    logic                       full;
    logic [tqv_pkg::ID_W-1:0]   tile_id = '0;
    logic [tqv_pkg::CELL_W-1:0] cell_col = '0, cell_row = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [tqv_pkg::POS_W-1:0]  pos_x, pos_y;
    logic [tqv_pkg::UV_W-1:0]   tex_u, tex_v;
    logic                       last_vertex;
    int                         errors, pending, hits, vertices;
    int                         quiet = 0;
    logic [31:0]                cur_first, cur_count;

    tile_quad_vertex_generator uut (.*);
    tqv_checker scoreboard (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles without any transfer.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stall before each vertex, with stall-free stretches.
    initial
    begin
        int gap;
        int burst;
        burst = 0;
        @(posedge rst_n);
        forever
        begin
            if (burst > 0)
            begin
                burst--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0)
                    burst = 40;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic reg_write(tqv_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tqv_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tqv_pkg::REG_FIRST_GID)
            cur_first = value;
        if (idx == tqv_pkg::REG_TILE_COUNT)
            cur_count = value;
        @(posedge clk);
    endtask

    // Stop sending, wait until all vertices are out, then let the back end settle.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_cell(logic [31:0] id, logic [9:0] col, logic [9:0] row, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        tile_id  <= id;
        cell_col <= col;
        cell_row <= row;
        do @(posedge clk); while (full);
    endtask

    task automatic configure(logic [31:0] first, logic [31:0] count, logic [31:0] cols,
                             logic [31:0] sheet, logic [31:0] map, logic [31:0] gb,
                             logic [31:0] tex);
        reg_write(tqv_pkg::REG_FIRST_GID, first);
        reg_write(tqv_pkg::REG_TILE_COUNT, count);
        reg_write(tqv_pkg::REG_SHEET_COLUMNS, cols);
        reg_write(tqv_pkg::REG_SHEET_TILE_SIZE, sheet);
        reg_write(tqv_pkg::REG_MAP_TILE_SIZE, map);
        reg_write(tqv_pkg::REG_GAP_AND_BORDER, gb);
        reg_write(tqv_pkg::REG_TEXTURE_SIZE, tex);
    endtask

    // Random cell: mostly in the tileset, sometimes outside or wild.
    task automatic random_cell(bit no_gap);
        logic [31:0] id;
        if ($urandom_range(0, 4) != 0 && cur_count != 0)
            id = cur_first + $urandom_range(0, (cur_count > 4000) ? 4000 : cur_count - 1);
        else
            id = $urandom();
        send_cell(id, 10'($urandom()), 10'($urandom()), no_gap);
    endtask

    initial
    begin
        cur_first = 32'd1;
        cur_count = 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: empty tileset, nothing should come out.
        send_cell(32'd1, 10'd0, 10'd0, 1'b0);
        drain();

        // Plain 16x16 sheet, 8 columns, 128x128 texture.
        configure(32'd1, 32'd64, 32'd8, 32'h0010_0010, 32'h0010_0010,
                  32'h0002_0001, 32'h0080_0080);
        send_cell(32'd1, 10'd0, 10'd0, 1'b0);
        send_cell(32'd64, 10'd1023, 10'd1023, 1'b0);
        send_cell(32'd65, 10'd3, 10'd3, 1'b0);
        send_cell(32'd0, 10'd3, 10'd3, 1'b0);
        send_cell(32'd9, 10'd512, 10'd5, 1'b0);
        drain();

        // Range end saturates rather than wrapping; zero columns; zero texture size.
        configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cell(32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b0);
        send_cell(32'hFFFF_FFF0, 10'd0, 10'd1, 1'b0);
        send_cell(32'h0000_0002, 10'd0, 10'd1, 1'b0);
        drain();

        // Largest texture, large gid range, widest sheet.
        configure(32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0100_0200, 32'h0001_FFFF,
                  32'h0000_0003, 32'hFFFF_FFFF);
        send_cell(32'd0, 10'd0, 10'd0, 1'b0);
        send_cell(32'hFFFF_FFFE, 10'h155, 10'h2AA, 1'b0);
        send_cell(32'hFFFF_FFFF, 10'd1, 10'd1, 1'b0);
        send_cell(32'd65535, 10'd7, 10'd9, 1'b0);
        drain();

        // Random phases with random configurations, saturating UVs often.
        for (int phase = 0; phase < 5; phase++)
        begin
            configure($urandom(), $urandom_range(1, 5000), $urandom_range(0, 40),
                      $urandom(), $urandom(), {16'($urandom_range(0, 8)), 16'($urandom())},
                      {16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))});
            for (int n = 0; n < 20; n++)
                random_cell(phase == 2);
            drain();
        end

        $display("Covered %0d tiles in the tileset producing %0d vertices,", hits, vertices);
        $display("over directed extremes and five random register settings.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ tile_quad_vertex_generator.f @@
design/tqv_pkg.sv
design/tqv_regs.sv
design/tqv_front.sv
design/tqv_fifo.sv
design/tqv_div.sv
design/tqv_back.sv
design/tile_quad_vertex_generator.sv
tb/tqv_checker.sv
tb/testbench.sv
